### sv/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the position-loop motor drive: register
// map, datapath widths and the request and status records of the multiplier.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int MCAND_W  = 65;
    localparam int MPLIER_W = 32;
    localparam int HI_W     = MCAND_W + 2;
    localparam int PROD_W   = 98;
    localparam int STEP_W   = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MPLIER_W / 2 - 1);

    localparam logic [2:0] REG_DEG_PER_COUNT = 3'd0;
    localparam logic [2:0] REG_KP            = 3'd1;
    localparam logic [2:0] REG_KI            = 3'd2;
    localparam logic [2:0] REG_KD            = 3'd3;
    localparam logic [2:0] REG_DUTY_LIMIT    = 3'd4;

    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_OPEN = 1'b1;

    localparam logic [31:0] DEG_PER_COUNT_RESET = 32'd188743680;
    localparam logic [16:0] FULL_DUTY           = 17'h10000;

    localparam logic signed [47:0] ANGLE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ANGLE_MIN = 48'sh8000_0000_0000;
    localparam logic signed [63:0] ESUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ESUM_MIN  = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [31:0]        deg_per_count;
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic [16:0]        duty_limit;
    } cfg_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0]        mplier;
    } mul_req_t;

    typedef struct packed {
        logic                       busy;
        logic signed [PROD_W-1:0]   product;
    } mul_rsp_t;

endpackage

### sv/pmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmd_cfg_regs
// Configuration register file behind the APB-style port: scale, gains and
// duty limit, with read-back.
// ----------------------------------------------------------------------------
module pmd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pmd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmd_pkg::DATA_W-1:0]   pwdata,
    output logic [pmd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output pmd_pkg::cfg_t                cfg
);
    import pmd_pkg::*;

    logic [2:0]         idx;
    logic               wr;
    logic [31:0]        deg_per_count_reg;
    logic signed [31:0] kp_reg;
    logic signed [31:0] ki_reg;
    logic signed [31:0] kd_reg;
    logic [16:0]        duty_limit_reg;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_per_count_reg <= DEG_PER_COUNT_RESET;
            kp_reg            <= '0;
            ki_reg            <= '0;
            kd_reg            <= '0;
            duty_limit_reg    <= FULL_DUTY;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_DEG_PER_COUNT: deg_per_count_reg <= pwdata;
                REG_KP:            kp_reg            <= pwdata;
                REG_KI:            ki_reg            <= pwdata;
                REG_KD:            kd_reg            <= pwdata;
                REG_DUTY_LIMIT:    duty_limit_reg    <= pwdata[16:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEG_PER_COUNT: prdata = deg_per_count_reg;
            REG_KP:            prdata = kp_reg;
            REG_KI:            prdata = ki_reg;
            REG_KD:            prdata = kd_reg;
            REG_DUTY_LIMIT:    prdata = {15'd0, duty_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.deg_per_count = deg_per_count_reg;
    assign cfg.kp            = kp_reg;
    assign cfg.ki            = ki_reg;
    assign cfg.kd            = kd_reg;
    assign cfg.duty_limit    = duty_limit_reg;

endmodule

### sv/pmd_booth_mul.sv
// ----------------------------------------------------------------------------
// pmd_booth_mul
// Digit-serial signed multiplier: radix-4 Booth, two multiplier bits per
// cycle, product low bits shifted out into a register, 16 steps.
// ----------------------------------------------------------------------------
module pmd_booth_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  pmd_pkg::mul_req_t   req,
    output pmd_pkg::mul_rsp_t   rsp
);
    import pmd_pkg::*;

    logic                       busy_reg;
    logic [STEP_W-1:0]          cnt_reg;
    logic signed [HI_W-1:0]     hi_reg;
    logic [MPLIER_W-1:0]        lo_reg;
    logic [MPLIER_W-1:0]        mq_reg;
    logic                       mb_reg;
    logic signed [MCAND_W-1:0]  x_reg;

    logic [2:0]                 trio;
    logic                       zero;
    logic                       two;
    logic                       neg;
    logic [HI_W-1:0]            x1;
    logic [HI_W-1:0]            x2;
    logic [HI_W-1:0]            mag;
    logic [HI_W-1:0]            addend;
    logic [HI_W-1:0]            sum;

    assign trio = {mq_reg[1:0], mb_reg};
    assign zero = (&trio) | (~|trio);
    assign two  = (trio[2] ^ trio[1]) & (trio[1] ~^ trio[0]);
    assign neg  = trio[2] & ~zero;

    assign x1     = {{2{x_reg[MCAND_W-1]}}, x_reg};
    assign x2     = {x_reg[MCAND_W-1], x_reg, 1'b0};
    assign mag    = zero ? '0 : (two ? x2 : x1);
    assign addend = neg ? ~mag : mag;
    assign sum    = hi_reg + addend + HI_W'(neg);

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // shift datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
            mq_reg <= req.mplier;
            mb_reg <= 1'b0;
            x_reg  <= req.mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= {{2{sum[HI_W-1]}}, sum[HI_W-1:2]};
            lo_reg <= {sum[1:0], lo_reg[MPLIER_W-1:2]};
            mq_reg <= {2'b00, mq_reg[MPLIER_W-1:2]};
            mb_reg <= mq_reg[1];
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.product = {hi_reg[PROD_W-MPLIER_W-1:0], lo_reg};

endmodule

### sv/pmd_clamp.sv
// ----------------------------------------------------------------------------
// pmd_clamp
// Clamps the Q.32 duty to the duty limit and full scale, then splits it into
// a direction bit and a Q1.16 magnitude.
// ----------------------------------------------------------------------------
module pmd_clamp (
    input  logic signed [pmd_pkg::PROD_W-1:0] acc,
    input  logic [16:0]                       duty_limit,
    output logic                              direction,
    output logic [16:0]                       duty_magnitude
);
    import pmd_pkg::*;

    logic [16:0]        lim;
    logic signed [33:0] bnd;
    logic signed [33:0] v;
    logic signed [33:0] d;
    logic [33:0]        d_abs;
    logic               in_range;

    assign lim      = (duty_limit > FULL_DUTY) ? FULL_DUTY : duty_limit;
    assign bnd      = {1'b0, lim, 16'd0};
    assign v        = acc[33:0];
    assign in_range = (acc[PROD_W-1:33] == {(PROD_W-33){acc[33]}});

    always_comb
    begin
        if (!in_range)
        begin
            d = acc[PROD_W-1] ? -bnd : bnd;
        end
        else if (v > bnd)
        begin
            d = bnd;
        end
        else if (v < -bnd)
        begin
            d = -bnd;
        end
        else
        begin
            d = v;
        end
    end

    assign d_abs          = d[33] ? -d : d;
    assign direction      = d[33] | (d == '0);
    assign duty_magnitude = d_abs[32:16];

endmodule

### sv/pid_position_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// pid_position_motor_drive_unit
// PID position controller with a direct-duty bypass, built around a shared
// digit-serial Booth multiplier.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_stall): one request per control step; func
//   selects a closed-loop step (angle_setpoint, enc_delta) or an open-loop duty
//   (open_duty). in_stall is high while a request is being worked on.
//   output channel (out_valid/out_stall): one result per request, direction
//   and duty_magnitude, held in an output register.
//   open-loop: the request goes from acceptance through the clamp step
//   to the output register. closed-loop: four passes of the radix-4
//   multiplier (angle increment, kp, kd, ki terms), with the angle and
//   error steps after the first pass and the clamp step after the last.
//   one request is worked on at a time by the single serial multiplier.
//   the next request is taken while a result waits in the output register;
//   a stalled receiver holds the result and blocks only the final clamp.
//   the user must write configuration through the APB-style port while idle;
//   the block does not enforce it. reset: registers return to their defaults,
//   angle, previous angle and error sum clear to zero, both channels go idle.
// ----------------------------------------------------------------------------
module pid_position_motor_drive_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pmd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmd_pkg::DATA_W-1:0]   pwdata,
    output logic [pmd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic signed [31:0]           angle_setpoint,
    input  logic signed [15:0]           enc_delta,
    input  logic signed [31:0]           open_duty,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         direction,
    output logic [16:0]                  duty_magnitude
);
    import pmd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ANGLE = 3'd2;
    localparam logic [2:0] S_ERROR = 3'd3;
    localparam logic [2:0] S_CLAMP = 3'd4;

    localparam logic [1:0] PH_ANG = 2'd0;
    localparam logic [1:0] PH_P   = 2'd1;
    localparam logic [1:0] PH_D   = 2'd2;
    localparam logic [1:0] PH_I   = 2'd3;

    cfg_t                       cfg;
    mul_req_t                   mul_req;
    mul_rsp_t                   mul_rsp;

    logic [2:0]                 state_reg,          state_next;
    logic [1:0]                 phase_reg,          phase_next;
    logic signed [31:0]         target_reg,         target_next;
    logic signed [47:0]         angle_now_reg,      angle_now_next;
    logic signed [47:0]         angle_prev_reg,     angle_prev_next;
    logic signed [63:0]         error_sum_reg,      error_sum_next;
    logic signed [PROD_W-1:0]   acc_reg,            acc_next;
    logic                       out_valid_reg,      out_valid_next;
    logic                       direction_reg,      direction_next;
    logic [16:0]                duty_magnitude_reg, duty_magnitude_next;

    logic signed [31:0]         ang_inc;
    logic signed [48:0]         angle_sum;
    logic signed [47:0]         angle_sat;
    logic signed [48:0]         err;
    logic signed [64:0]         err_acc;
    logic signed [63:0]         err_sat;
    logic signed [48:0]         diff_p;
    logic signed [48:0]         diff_d;
    logic signed [MCAND_W-1:0]  mcand_i;
    logic signed [PROD_W-1:0]   acc_sum;
    logic                       clamp_dir;
    logic [16:0]                clamp_mag;
    logic                       out_free;

    pmd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmd_booth_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pmd_clamp u_clamp (
        .acc            (acc_reg),
        .duty_limit     (cfg.duty_limit),
        .direction      (clamp_dir),
        .duty_magnitude (clamp_mag)
    );

    // angle increment is the Q.32 product floored to Q.16
    assign ang_inc   = mul_rsp.product[47:16];
    assign angle_sum = {angle_now_reg[47], angle_now_reg} + {{17{ang_inc[31]}}, ang_inc};
    assign angle_sat = (angle_sum[48] != angle_sum[47])
                       ? (angle_sum[48] ? ANGLE_MIN : ANGLE_MAX)
                       : angle_sum[47:0];

    assign err     = {angle_now_reg[47], angle_now_reg} - {{17{target_reg[31]}}, target_reg};
    assign err_acc = {error_sum_reg[63], error_sum_reg} + {{16{err[48]}}, err};
    assign err_sat = (err_acc[64] != err_acc[63])
                     ? (err_acc[64] ? ESUM_MIN : ESUM_MAX)
                     : err_acc[63:0];

    assign diff_p  = {{17{target_reg[31]}}, target_reg} - {angle_now_reg[47], angle_now_reg};
    assign diff_d  = {angle_prev_reg[47], angle_prev_reg} - {angle_now_reg[47], angle_now_reg};
    assign mcand_i = MCAND_W'(0) - {error_sum_reg[63], error_sum_reg};
    assign acc_sum = acc_reg + mul_rsp.product;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        target_next         = target_reg;
        angle_now_next      = angle_now_reg;
        angle_prev_next     = angle_prev_reg;
        error_sum_next      = error_sum_reg;
        acc_next            = acc_reg;
        out_valid_next      = out_valid_reg & out_stall;
        direction_next      = direction_reg;
        duty_magnitude_next = duty_magnitude_reg;
        mul_req.start       = 1'b0;
        mul_req.mcand       = '0;
        mul_req.mplier      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    target_next = angle_setpoint;
                    if (func == FUNC_OPEN)
                    begin
                        acc_next   = {{(PROD_W-48){open_duty[31]}}, open_duty, 16'd0};
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = {{(MCAND_W-32){1'b0}}, cfg.deg_per_count};
                        mul_req.mplier = {{16{enc_delta[15]}}, enc_delta};
                        phase_next     = PH_ANG;
                        state_next     = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (!mul_rsp.busy)
                begin
                    unique case (phase_reg)
                        PH_ANG:
                        begin
                            state_next = S_ANGLE;
                        end
                        PH_P:
                        begin
                            acc_next        = acc_sum;
                            angle_prev_next = angle_now_reg;
                            mul_req.start   = 1'b1;
                            mul_req.mcand   = {{(MCAND_W-49){diff_d[48]}}, diff_d};
                            mul_req.mplier  = cfg.kd;
                            phase_next      = PH_D;
                        end
                        PH_D:
                        begin
                            acc_next       = acc_sum;
                            mul_req.start  = 1'b1;
                            mul_req.mcand  = mcand_i;
                            mul_req.mplier = cfg.ki;
                            phase_next     = PH_I;
                        end
                        PH_I:
                        begin
                            acc_next   = acc_sum;
                            state_next = S_CLAMP;
                        end
                    endcase
                end
            end
            S_ANGLE:
            begin
                angle_now_next = angle_sat;
                state_next     = S_ERROR;
            end
            S_ERROR:
            begin
                error_sum_next = err_sat;
                acc_next       = '0;
                mul_req.start  = 1'b1;
                mul_req.mcand  = {{(MCAND_W-49){diff_p[48]}}, diff_p};
                mul_req.mplier = cfg.kp;
                phase_next     = PH_P;
                state_next     = S_MUL;
            end
            S_CLAMP:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    direction_next      = clamp_dir;
                    duty_magnitude_next = clamp_mag;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_ANG;
            angle_now_reg  <= '0;
            angle_prev_reg <= '0;
            error_sum_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            angle_now_reg  <= angle_now_next;
            angle_prev_reg <= angle_prev_next;
            error_sum_reg  <= error_sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg         <= target_next;
        acc_reg            <= acc_next;
        direction_reg      <= direction_next;
        duty_magnitude_reg <= duty_magnitude_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign direction      = direction_reg;
    assign duty_magnitude = duty_magnitude_reg;

    a_result_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_CLAMP))
        else $error("result raised outside the clamp step");

    a_mul_idle_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mul_rsp.busy)
        else $error("multiplier busy while waiting for a request");

    a_angle_update_step: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_now_reg != $past(angle_now_reg)) |-> $past(state_reg == S_ANGLE))
        else $error("angle changed outside the angle update step");

    a_prev_follows_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_prev_reg != $past(angle_prev_reg)) |-> (angle_prev_reg == angle_now_reg))
        else $error("previous angle loaded with something other than the angle");

endmodule

### dv/pmd_duty_checker.sv
// ----------------------------------------------------------------------------
// pmd_duty_checker
// Watches the configuration port and the request and result channels of the
// position motor drive, keeps its own copy of the registers and the loop
// state, works out the duty of every accepted request and compares it with
// each result that leaves the block.
// ----------------------------------------------------------------------------
module pmd_duty_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [pmd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmd_pkg::DATA_W-1:0]   pwdata,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         func,
    input  logic signed [31:0]           angle_setpoint,
    input  logic signed [15:0]           enc_delta,
    input  logic signed [31:0]           open_duty,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         direction,
    input  logic [16:0]                  duty_magnitude,
    output int                           fail_count,
    output int                           duty_backlog
);
    timeunit 1ns;
    timeprecision 1ps;
    import pmd_pkg::*;

    typedef struct packed {
        logic        dir;
        logic [16:0] mag;
    } duty_t;

    logic [31:0]        deg_per_count;
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic [16:0]        duty_limit;

    logic signed [47:0] angle_now;
    logic signed [47:0] angle_prev;
    logic signed [63:0] error_sum;

    duty_t duty_due[$];
    duty_t want;
    int    errs;

    function automatic duty_t pid_duty(input logic fn, input logic signed [31:0] tgt,
                                       input logic signed [15:0] dlt,
                                       input logic signed [31:0] od);
        logic [16:0]         lim;
        logic signed [63:0]  d;
        logic signed [63:0]  lim_s;
        logic signed [63:0]  step;
        logic signed [63:0]  ang;
        logic signed [64:0]  esum_w;
        logic signed [127:0] acc;
        logic signed [127:0] bnd;
        logic signed [127:0] mag_w;
        duty_t               r;
        lim = (duty_limit > FULL_DUTY) ? FULL_DUTY : duty_limit;
        if (fn == FUNC_OPEN)
        begin
            d     = od;
            lim_s = {47'd0, lim};
            if (d > lim_s)
                d = lim_s;
            if (d < -lim_s)
                d = -lim_s;
            r.dir = (d > 0) ? 1'b0 : 1'b1;
            r.mag = (d < 0) ? 17'(-d) : 17'(d);
        end
        else
        begin
            // encoder step in q.32, floored to q.16
            step = dlt * $signed({1'b0, deg_per_count});
            ang  = angle_now + (step >>> 16);
            if (ang > ANGLE_MAX)
                ang = ANGLE_MAX;
            else if (ang < ANGLE_MIN)
                ang = ANGLE_MIN;
            angle_now = ang[47:0];
            esum_w = error_sum + (angle_now - tgt);
            if (esum_w > ESUM_MAX)
                error_sum = ESUM_MAX;
            else if (esum_w < ESUM_MIN)
                error_sum = ESUM_MIN;
            else
                error_sum = esum_w[63:0];
            acc = (tgt - angle_now) * kp - (angle_now - angle_prev) * kd - error_sum * ki;
            angle_prev = angle_now;
            bnd = lim;
            bnd = bnd <<< 16;
            if (acc < -bnd)
                acc = -bnd;
            else if (acc > bnd)
                acc = bnd;
            mag_w = (acc < 0) ? -acc : acc;
            r.dir = (acc > 0) ? 1'b0 : 1'b1;
            r.mag = mag_w[32:16];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_per_count = DEG_PER_COUNT_RESET;
            kp            = '0;
            ki            = '0;
            kd            = '0;
            duty_limit    = FULL_DUTY;
            angle_now     = '0;
            angle_prev    = '0;
            error_sum     = '0;
            errs          = 0;
            duty_due.delete();
            fail_count   <= 0;
            duty_backlog <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (duty_due.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t: result with nothing due: dir %0d mag %0d",
                                 $realtime, direction, duty_magnitude);
                    errs++;
                end
                else
                begin
                    want = duty_due.pop_front();
                    if (want.dir !== direction || want.mag !== duty_magnitude)
                    begin
                        if (errs < 10)
                            $display("%0t: expected dir %0d mag %0d, got dir %0d mag %0d",
                                     $realtime, want.dir, want.mag, direction,
                                     duty_magnitude);
                        errs++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_DEG_PER_COUNT: deg_per_count = pwdata;
                    REG_KP:            kp            = pwdata;
                    REG_KI:            ki            = pwdata;
                    REG_KD:            kd            = pwdata;
                    REG_DUTY_LIMIT:    duty_limit    = pwdata[16:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                duty_due.push_back(pid_duty(func, angle_setpoint, enc_delta, open_duty));
            fail_count   <= errs;
            duty_backlog <= duty_due.size();
        end
    end

endmodule

### dv/tb_pid_position_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// tb_pid_position_motor_drive_unit
// Drives the position motor drive with directed corner requests and then
// random closed-loop and open-loop requests over a series of register
// settings, with random idling on both channels; the checker beside the
// block scores every result.
// ----------------------------------------------------------------------------
module tb_pid_position_motor_drive_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pmd_pkg::*;

    localparam int   QUIET_LIMIT = 2000;
    localparam int   PHASES      = 8;
    localparam int   PHASE_REQS  = 92;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_W-1:0]    paddr          = '0;
    logic [DATA_W-1:0]    pwdata         = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 func           = FUNC_STEP;
    logic signed [31:0]   angle_setpoint = '0;
    logic signed [15:0]   enc_delta      = '0;
    logic signed [31:0]   open_duty      = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 direction;
    logic [16:0]          duty_magnitude;

    int   fail_count;
    int   duty_backlog;
    logic calm    = 1'b0;
    int   rx_left = 0;
    int   quiet   = 0;

    pid_position_motor_drive_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .angle_setpoint (angle_setpoint),
        .enc_delta      (enc_delta),
        .open_duty      (open_duty),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .direction      (direction),
        .duty_magnitude (duty_magnitude)
    );

    pmd_duty_checker CHK (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .angle_setpoint (angle_setpoint),
        .enc_delta      (enc_delta),
        .open_duty      (open_duty),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .direction      (direction),
        .duty_magnitude (duty_magnitude),
        .fail_count     (fail_count),
        .duty_backlog   (duty_backlog)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: stall bursts and free runs in random order, free while calm
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (rx_left <= 1)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                rx_left   <= $urandom_range(1, 18);
            end
            else
            begin
                out_stall <= 1'b0;
                rx_left   <= $urandom_range(1, 40);
            end
        end
        else
            rx_left <= rx_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("pid_position_motor_drive_unit verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [31:0] rnd32();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - $urandom_range(1, 32));
    endfunction

    function automatic logic [15:0] rnd16();
        logic signed [15:0] v;
        v = $urandom;
        return v >>> (16 - $urandom_range(1, 16));
    endfunction

    task automatic send_request(input logic fn, input logic [31:0] tgt,
                                input logic [15:0] dlt, input logic [31:0] od);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= fn;
        angle_setpoint <= tgt;
        enc_delta      <= dlt;
        open_duty      <= od;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (duty_backlog != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] dpc, input logic [31:0] p,
                              input logic [31:0] i, input logic [31:0] d,
                              input logic [16:0] lim);
        wait_drained();
        write_reg(REG_DEG_PER_COUNT, dpc);
        write_reg(REG_KP, p);
        write_reg(REG_KI, i);
        write_reg(REG_KD, d);
        write_reg(REG_DUTY_LIMIT, {15'd0, lim});
    endtask

    task automatic random_config();
        logic [31:0] dpc;
        logic [16:0] lim;
        case ($urandom_range(0, 3))
            0:       dpc = DEG_PER_COUNT_RESET;
            1:       dpc = $urandom;
            2:       dpc = $urandom >> $urandom_range(0, 31);
            default: dpc = $urandom_range(0, 1) ? '1 : '0;
        endcase
        case ($urandom_range(0, 3))
            0:       lim = FULL_DUTY;
            1:       lim = 17'($urandom_range(0, 65536));
            2:       lim = 17'($urandom_range(65537, 131071));
            default: lim = 17'($urandom_range(0, 2048));
        endcase
        set_config(dpc, rnd32(), rnd32(), rnd32(), lim);
    endtask

    initial
    begin
        int p;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tiny gain, full-scale encoder step
        set_config(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, FULL_DUTY);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'd0);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'd1);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'hFFFF_FFFF);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h7FFF_FFFF);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h8000_0000);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h0001_0000);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h0001_0001);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'hFFFF_0000);
        send_request(FUNC_STEP, 32'd100, 16'd0, 32'd0);
        send_request(FUNC_STEP, 32'h7FFF_FFFF, 16'h7FFF, 32'h7FFF_FFFF);
        send_request(FUNC_STEP, 32'h8000_0000, 16'h8000, 32'h8000_0000);
        send_request(FUNC_STEP, 32'd0, 16'hFFFF, 32'd0);
        send_request(FUNC_STEP, 32'd0, 16'd0, 32'd0);

        // zero limit, extreme gains, no encoder scaling
        set_config(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 17'd0);
        send_request(FUNC_STEP, 32'h1234_5678, 16'h7FFF, 32'd0);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h7FFF_FFFF);

        // limit above full scale
        set_config(DEG_PER_COUNT_RESET, 32'h8000_0000, 32'd1, 32'h8000_0000, 17'h1FFFF);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h7FFF_FFFF);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'h0001_8000);
        send_request(FUNC_STEP, 32'd0, 16'h7FFF, 32'd0);
        send_request(FUNC_STEP, 32'h0001_2345, 16'h8000, 32'd0);
        send_request(FUNC_OPEN, 32'd0, 16'd0, 32'hFFFE_EE90);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                calm <= 1'b1;
            random_config();
            for (n = 0; n < PHASE_REQS; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
                send_request(($urandom_range(0, 9) < 3) ? FUNC_OPEN : FUNC_STEP,
                             rnd32(), rnd16(), rnd32());
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && duty_backlog == 0)
            $display("pid_position_motor_drive_unit verification clean");
        else
            $display("pid_position_motor_drive_unit verification failed");
        $finish;
    end

endmodule
